/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the lexer RTL.
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg)

`endif

`endif

/* rtl/btl_pkg.sv */
// ----------------------------------------------------------------------------
// btl_pkg
// Shared types and codes of the brace token lexer: token kinds, lexer
// modes, register indexes and the job record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package btl_pkg;

  // Token kinds on the result port
  localparam logic [2:0] TK_SYM_CHAR = 3'd0;
  localparam logic [2:0] TK_STR_CHAR = 3'd1;
  localparam logic [2:0] TK_SYM_END  = 3'd2;
  localparam logic [2:0] TK_STR_END  = 3'd3;
  localparam logic [2:0] TK_LBRACE   = 3'd4;
  localparam logic [2:0] TK_RBRACE   = 3'd5;
  localparam logic [2:0] TK_END      = 3'd6;

  // Configuration register indexes
  localparam int unsigned    REG_IDX_W     = 3;
  localparam logic [2:0]     REG_LBRACE    = 3'd0;
  localparam logic [2:0]     REG_RBRACE    = 3'd1;
  localparam logic [2:0]     REG_QUOTE     = 3'd2;
  localparam logic [2:0]     REG_ESCAPE    = 3'd3;
  localparam logic [2:0]     REG_COMMENT   = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_LBRACE  = 8'd123;
  localparam logic [7:0] RST_RBRACE  = 8'd125;
  localparam logic [7:0] RST_QUOTE   = 8'd34;
  localparam logic [7:0] RST_ESCAPE  = 8'd92;
  localparam logic [7:0] RST_COMMENT = 8'd59;

  // Fixed characters
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_N     = 8'd110;
  localparam logic [7:0] CH_R     = 8'd114;

  // Job queue sizing
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Lexer mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_CMT_NL  = 5'b00100,
    MODE_STRING  = 5'b01000,
    MODE_ESCAPE  = 5'b10000
  } lex_mode_t;

  // One input item's tokens: one or two of them
  typedef struct packed {
    logic       two;
    logic [2:0] kind_a;
    logic [2:0] kind_b;
    logic [7:0] ch;
  } job_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/brace_token_lexer_core.sv */
// ----------------------------------------------------------------------------
// brace_token_lexer_core
// Streaming lexer for brace-structured text with strings and line comments.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle (a byte or an end-of-stream mark)
// while the queue has room and emits one token beat per cycle while out_ready
// is high. A beat yields zero, one or two tokens; the front lexes it in the
// cycle it is accepted and queues a job in a four-entry queue; the emitter
// drains one token per cycle through a registered output, so a two-token
// beat takes two output beats and the output port sets the sustained rate
// for back-to-back such beats. The user must write the five special bytes via
// the register port only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module brace_token_lexer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [btl_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [7:0]                    wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [7:0]                    byte_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         token_kind,
  output logic [7:0]                         char_out,
  output logic                               last
);

  btl_pkg::q_stat_t q_stat;
  btl_pkg::job_t    push_job;
  btl_pkg::job_t    head;
  logic             push;
  logic             pop;

  btl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .byte_in  (byte_in),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  btl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  btl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_kind (token_kind),
    .char_out   (char_out),
    .last       (last)
  );

endmodule

`default_nettype wire

/* rtl/btl_front.sv */
// ----------------------------------------------------------------------------
// btl_front
// Accepts input beats, holds the brace/quote/escape/comment registers and the
// lexer mode, and turns each beat into a job of zero, one or two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module btl_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [btl_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [7:0]                    wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [7:0]                    byte_in,
  input  wire btl_pkg::q_stat_t              q_stat,
  output logic                               push,
  output btl_pkg::job_t                      push_job
);

  logic [7:0] lbrace_ch;
  logic [7:0] rbrace_ch;
  logic [7:0] quote_ch;
  logic [7:0] escape_ch;
  logic [7:0] comment_ch;

  btl_pkg::lex_mode_t mode;
  btl_pkg::lex_mode_t mode_next;
  logic               sym_open;
  logic               sym_open_next;

  logic               take;
  logic               emit;
  btl_pkg::job_t      job;

  // Outside-string handling
  logic               is_sep;
  logic               is_nl;
  logic               o_emit;
  btl_pkg::job_t      o_job;
  btl_pkg::lex_mode_t o_mode;
  logic               o_sym;

  logic [7:0]         esc_ch;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lbrace_ch  <= btl_pkg::RST_LBRACE;
      rbrace_ch  <= btl_pkg::RST_RBRACE;
      quote_ch   <= btl_pkg::RST_QUOTE;
      escape_ch  <= btl_pkg::RST_ESCAPE;
      comment_ch <= btl_pkg::RST_COMMENT;
    end else if (wr_en) begin
      unique case (wr_index)
        btl_pkg::REG_LBRACE:  lbrace_ch  <= wr_data;
        btl_pkg::REG_RBRACE:  rbrace_ch  <= wr_data;
        btl_pkg::REG_QUOTE:   quote_ch   <= wr_data;
        btl_pkg::REG_ESCAPE:  escape_ch  <= wr_data;
        btl_pkg::REG_COMMENT: comment_ch <= wr_data;
        default: ;
      endcase
    end
  end

  assign is_sep = (byte_in == btl_pkg::CH_SPACE) ||
                  ((byte_in >= btl_pkg::CH_TAB) && (byte_in <= btl_pkg::CH_CR));
  assign is_nl  = (byte_in == btl_pkg::CH_LF) || (byte_in == btl_pkg::CH_CR);

  // Map the byte after an escape
  always_comb begin
    if (byte_in == btl_pkg::CH_N) begin
      esc_ch = btl_pkg::CH_LF;
    end else if (byte_in == btl_pkg::CH_R) begin
      esc_ch = btl_pkg::CH_CR;
    end else begin
      esc_ch = byte_in;
    end
  end

  // Classify a byte seen outside strings and comments
  always_comb begin
    o_emit = 1'b0;
    o_job  = '0;
    o_mode = btl_pkg::MODE_IDLE;
    o_sym  = 1'b0;
    if (is_sep) begin
      o_emit       = sym_open;
      o_job.kind_a = btl_pkg::TK_SYM_END;
    end else if (byte_in == lbrace_ch || byte_in == rbrace_ch) begin
      o_emit = 1'b1;
      if (sym_open) begin
        o_job.two    = 1'b1;
        o_job.kind_a = btl_pkg::TK_SYM_END;
        o_job.kind_b = (byte_in == lbrace_ch) ? btl_pkg::TK_LBRACE : btl_pkg::TK_RBRACE;
      end else begin
        o_job.kind_a = (byte_in == lbrace_ch) ? btl_pkg::TK_LBRACE : btl_pkg::TK_RBRACE;
      end
    end else if (byte_in == comment_ch) begin
      o_mode = btl_pkg::MODE_COMMENT;
      o_sym  = sym_open;
    end else if (byte_in == quote_ch) begin
      o_emit       = sym_open;
      o_job.kind_a = btl_pkg::TK_SYM_END;
      o_mode       = btl_pkg::MODE_STRING;
    end else begin
      o_emit       = 1'b1;
      o_job.kind_a = btl_pkg::TK_SYM_CHAR;
      o_job.ch     = byte_in;
      o_sym        = 1'b1;
    end
  end

  // Advance the lexer mode for the current beat
  always_comb begin
    mode_next     = mode;
    sym_open_next = sym_open;
    emit          = 1'b0;
    job           = '0;
    if (kind) begin
      emit          = 1'b1;
      mode_next     = btl_pkg::MODE_IDLE;
      sym_open_next = 1'b0;
      if (mode == btl_pkg::MODE_STRING || mode == btl_pkg::MODE_ESCAPE) begin
        job.two    = 1'b1;
        job.kind_a = btl_pkg::TK_STR_END;
        job.kind_b = btl_pkg::TK_END;
      end else if (sym_open) begin
        job.two    = 1'b1;
        job.kind_a = btl_pkg::TK_SYM_END;
        job.kind_b = btl_pkg::TK_END;
      end else begin
        job.kind_a = btl_pkg::TK_END;
      end
    end else begin
      unique case (mode)
        btl_pkg::MODE_COMMENT: begin
          if (is_nl) begin
            mode_next = btl_pkg::MODE_CMT_NL;
          end
        end
        btl_pkg::MODE_CMT_NL: begin
          if (!is_nl) begin
            emit          = o_emit;
            job           = o_job;
            mode_next     = o_mode;
            sym_open_next = o_sym;
          end
        end
        btl_pkg::MODE_STRING: begin
          if (byte_in == quote_ch) begin
            emit       = 1'b1;
            job.kind_a = btl_pkg::TK_STR_END;
            mode_next  = btl_pkg::MODE_IDLE;
          end else if (byte_in == escape_ch) begin
            mode_next = btl_pkg::MODE_ESCAPE;
          end else begin
            emit       = 1'b1;
            job.kind_a = btl_pkg::TK_STR_CHAR;
            job.ch     = byte_in;
          end
        end
        btl_pkg::MODE_ESCAPE: begin
          emit       = 1'b1;
          job.kind_a = btl_pkg::TK_STR_CHAR;
          job.ch     = esc_ch;
          mode_next  = btl_pkg::MODE_STRING;
        end
        default: begin
          emit          = o_emit;
          job           = o_job;
          mode_next     = o_mode;
          sym_open_next = o_sym;
        end
      endcase
    end
  end

  // Hold lexer state between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= btl_pkg::MODE_IDLE;
      sym_open <= 1'b0;
    end else if (take) begin
      mode     <= mode_next;
      sym_open <= sym_open_next;
    end
  end

  assign push     = take && emit;
  assign push_job = job;

endmodule

`default_nettype wire

/* rtl/btl_queue.sv */
// ----------------------------------------------------------------------------
// btl_queue
// Short job queue between the lexer front and the token emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module btl_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire btl_pkg::job_t    push_job,
  input  wire logic             pop,
  output btl_pkg::job_t         head,
  output btl_pkg::q_stat_t      q_stat
);

  btl_pkg::job_t                entries [btl_pkg::QDEPTH];
  logic [btl_pkg::QAW-1:0]      wr_ptr;
  logic [btl_pkg::QAW-1:0]      rd_ptr;
  logic [btl_pkg::QCW-1:0]      count;
  logic                         do_push;
  logic                         do_pop;

  assign q_stat.full  = (count == btl_pkg::QCW'(btl_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= btl_pkg::QCW'(btl_pkg::QDEPTH), "queue count overflow")
  `ASSERT_IMPLY(a_no_push_full, clk, rst, push, !q_stat.full, "job pushed into full queue")

endmodule

`default_nettype wire

/* rtl/btl_back.sv */
// ----------------------------------------------------------------------------
// btl_back
// Token emitter: takes queued jobs and, unless out_ready stalls, drives one
// token beat per cycle via an output register, two beats per two-token job.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module btl_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire btl_pkg::job_t    head,
  input  wire btl_pkg::q_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            token_kind,
  output logic [7:0]            char_out,
  output logic                  last
);

  logic phase;
  logic load;

  // Load a new beat when the output slot is free or being taken
  assign load = !q_stat.empty && (!out_valid || out_ready);
  assign pop  = load && (phase || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      phase     <= !phase && head.two;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Select the payload of the next beat
  always_ff @(posedge clk) begin
    if (load) begin
      if (phase) begin
        token_kind <= head.kind_b;
        char_out   <= '0;
        last       <= 1'b1;
      end else begin
        token_kind <= head.kind_a;
        char_out   <= head.ch;
        last       <= !head.two;
      end
    end
  end

  `ASSERT_IMPLY(a_phase_first_beat, clk, rst, phase, out_valid && !last, "second token pending without first beat")
  `ASSERT_IMPLY(a_phase_head, clk, rst, phase, !q_stat.empty && head.two, "second token pending without its job")

endmodule

`default_nettype wire
